[rtl/kic_pkg.sv]
// Shared types and codes for the keypad integer calculator.
// No dependencies; the arithmetic unit, top level, checker and testbench import this package.
package kic_pkg;

  // Keypad command codes (codes six and seven are ignored)
  localparam logic [2:0] CMD_DIGIT  = 3'd0;
  localparam logic [2:0] CMD_PLUS   = 3'd1;
  localparam logic [2:0] CMD_MINUS  = 3'd2;
  localparam logic [2:0] CMD_TIMES  = 3'd3;
  localparam logic [2:0] CMD_DIVIDE = 3'd4;
  localparam logic [2:0] CMD_ENTER  = 3'd5;

  // Latched operation
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Arithmetic unit functions; the first four line up with op_t
  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_MUL   = 3'd2,
    FN_DIV   = 3'd3,
    FN_MAC10 = 3'd4
  } alu_fn_t;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic       start;
    alu_fn_t    fn;
    logic [3:0] digit;
  } alu_req_t;

  // Status back from the arithmetic unit
  typedef struct packed {
    logic done;
    logic dz;
  } alu_stat_t;

endpackage

[rtl/kic_in_if.sv]
// Keypad event channel: valid/ready handshake carrying one key word.
// Depends on nothing.
interface kic_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] digit;

  modport source (output valid, output command, output digit, input ready);
  modport sink   (input valid, input command, input digit, output ready);
endinterface

[rtl/kic_out_if.sv]
// Result channel: valid/ready handshake carrying one result word.
// Depends on nothing.
interface kic_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         divide_by_zero;

  modport source (output valid, output value, output divide_by_zero, input ready);
  modport sink   (input valid, input value, input divide_by_zero, output ready);
endinterface

[rtl/kic_alu.sv]
// Serial arithmetic unit: bit-serial add, subtract and times-ten-plus-digit,
// radix-2 multiply and restoring divide. Depends on kic_pkg.
module kic_alu import kic_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  alu_req_t              req,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output alu_stat_t             stat,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIX
  } alu_state_t;

  alu_state_t            state_r;
  alu_fn_t               fn_r;
  logic [DATA_WIDTH-1:0] sa_r;
  logic [DATA_WIDTH-1:0] sb_r;
  logic [DATA_WIDTH-1:0] res_r;
  logic [1:0]            carry_r;
  logic [2:0]            hist_r;
  logic [CW-1:0]         cnt_r;
  logic                  neg_r;
  logic                  dz_r;
  logic                  done_r;

  // Per-bit serial sums
  logic [1:0]            add_sum;
  logic [2:0]            mac_sum;
  // Divide trial subtract
  logic [DATA_WIDTH:0]   div_rem;
  logic [DATA_WIDTH:0]   div_diff;
  // Operand load values at start
  logic [DATA_WIDTH-1:0] ld_a;
  logic [DATA_WIDTH-1:0] ld_b;
  logic                  start_dz;
  logic                  start_neg;

  assign add_sum  = {1'b0, sa_r[0]} + {1'b0, sb_r[0] ^ (fn_r == FN_SUB)} + {1'b0, carry_r[0]};
  // x*10 = (x<<1) + (x<<3): bit i takes x[i-1] and x[i-3] from the history
  assign mac_sum  = {2'b00, hist_r[0]} + {2'b00, hist_r[2]} + {2'b00, sb_r[0]}
                  + {1'b0, carry_r};
  assign div_rem  = {res_r, sa_r[DATA_WIDTH-1]};
  assign div_diff = div_rem - {1'b0, sb_r};

  assign stat.done = done_r;
  assign stat.dz   = dz_r;
  assign result    = res_r;

  // Operands as loaded: digit for times-ten, magnitudes for divide
  always_comb begin
    ld_a      = a;
    ld_b      = b;
    start_dz  = 1'b0;
    start_neg = 1'b0;
    case (req.fn)
      FN_MAC10: begin
        ld_b = {{(DATA_WIDTH-4){1'b0}}, req.digit};
      end
      FN_DIV: begin
        // work on magnitudes, fix the sign at the end
        ld_a      = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        ld_b      = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
        start_neg = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        start_dz  = (b == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      dz_r    <= 1'b0;
      fn_r    <= FN_ADD;
    end else begin
      case (state_r)
        A_IDLE: begin
          if (req.start) begin
            fn_r    <= req.fn;
            cnt_r   <= CW'(DATA_WIDTH - 1);
            carry_r <= {1'b0, req.fn == FN_SUB};
            hist_r  <= '0;
            dz_r    <= start_dz;
            neg_r   <= start_neg;
            res_r   <= '0;
            sa_r    <= ld_a;
            sb_r    <= ld_b;
            // divide by zero finishes at once
            done_r  <= start_dz;
            state_r <= start_dz ? A_IDLE : A_RUN;
          end else begin
            done_r <= 1'b0;
          end
        end
        A_RUN: begin
          cnt_r <= cnt_r - 1'b1;
          case (fn_r)
            FN_ADD, FN_SUB: begin
              res_r   <= {add_sum[0], res_r[DATA_WIDTH-1:1]};
              carry_r <= {1'b0, add_sum[1]};
              sa_r    <= sa_r >> 1;
              sb_r    <= sb_r >> 1;
            end
            FN_MAC10: begin
              res_r   <= {mac_sum[0], res_r[DATA_WIDTH-1:1]};
              carry_r <= mac_sum[2:1];
              hist_r  <= {hist_r[1:0], sa_r[0]};
              sa_r    <= sa_r >> 1;
              sb_r    <= sb_r >> 1;
            end
            FN_MUL: begin
              if (sb_r[0]) begin
                res_r <= res_r + sa_r;
              end
              sa_r <= sa_r << 1;
              sb_r <= sb_r >> 1;
            end
            default: begin
              // restoring divide, one quotient bit per cycle into sa_r
              if (!div_diff[DATA_WIDTH]) begin
                res_r <= div_diff[DATA_WIDTH-1:0];
                sa_r  <= {sa_r[DATA_WIDTH-2:0], 1'b1};
              end else begin
                res_r <= div_rem[DATA_WIDTH-1:0];
                sa_r  <= {sa_r[DATA_WIDTH-2:0], 1'b0};
              end
            end
          endcase
          if (cnt_r == '0) begin
            if (fn_r == FN_DIV) begin
              done_r  <= 1'b0;
              state_r <= A_FIX;
            end else begin
              done_r  <= 1'b1;
              state_r <= A_IDLE;
            end
          end else begin
            done_r <= 1'b0;
          end
        end
        A_FIX: begin
          res_r   <= neg_r ? (~sa_r + 1'b1) : sa_r;
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= A_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/keypad_integer_calculator_top.sv]
// Keypad integer calculator top level: key sequencer, operand registers
// and result register. Depends on kic_pkg, kic_in_if, kic_out_if, kic_alu.
//
//   Channel | Dir | Word
//   in_ch   | in  | command[2:0], digit[3:0]
//   out_ch  | out | value[DATA_WIDTH-1:0] signed, divide_by_zero
//
// Operator keys and unused codes are handled in idle. A digit runs the
// bit-serial times-ten-plus-digit in the serial unit; enter runs it for
// add, subtract and multiply, and for divide adds a sign fix step (one bit
// per cycle in the serial unit); divide by zero finishes without a serial
// run. No new key is taken until the digit or enter is through.
// Synchronous active-low reset clears operands, operation and handshakes.
// Keys are taken while a result waits on out_ch; a second enter then waits
// for the result register to drain before returning to idle.
module keypad_integer_calculator_top import kic_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  kic_in_if.sink    in_ch,
  kic_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIGIT,
    S_CALC,
    S_HOLD
  } seq_state_t;

  seq_state_t                   state_r;
  logic [DATA_WIDTH-1:0]        first_r;
  logic [DATA_WIDTH-1:0]        second_r;
  op_t                          op_r;
  logic                         entering_second_r;
  logic                         sel_second_r;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic                         out_dz_r;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  alu_req_t              alu_req;
  alu_stat_t             alu_stat;
  logic [DATA_WIDTH-1:0] alu_a;
  logic [DATA_WIDTH-1:0] alu_b;
  logic [DATA_WIDTH-1:0] alu_res;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign accept                = in_ch.valid && in_ch.ready;
  assign out_free              = !out_valid_r || out_ch.ready;
  // result word moves into the output register this cycle
  assign out_load              = ((state_r == S_CALC && alu_stat.done) || state_r == S_HOLD)
                                 && out_free;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.value          = out_value_r;
  assign out_ch.divide_by_zero = out_dz_r;

  // Start the serial unit on an accepted digit or enter word
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.fn    = alu_fn_t'({1'b0, op_r});
    alu_req.digit = in_ch.digit;
    alu_a         = first_r;
    alu_b         = second_r;
    if (accept && in_ch.command == CMD_DIGIT) begin
      alu_req.start = 1'b1;
      alu_req.fn    = FN_MAC10;
      alu_a         = entering_second_r ? second_r : first_r;
    end else if (accept && in_ch.command == CMD_ENTER) begin
      alu_req.start = 1'b1;
    end
  end

  kic_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .stat   (alu_stat),
    .result (alu_res)
  );

  // Sequencer, operand state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      first_r           <= '0;
      second_r          <= '0;
      op_r              <= OP_ADD;
      entering_second_r <= 1'b0;
      sel_second_r      <= 1'b0;
      out_valid_r       <= 1'b0;
      out_dz_r          <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.command) inside
              CMD_DIGIT: begin
                sel_second_r <= entering_second_r;
                state_r      <= S_DIGIT;
              end
              [CMD_PLUS:CMD_DIVIDE]: begin
                op_r              <= op_t'(2'(in_ch.command - CMD_PLUS));
                entering_second_r <= 1'b1;
              end
              CMD_ENTER: begin
                // operands already captured by the serial unit
                first_r           <= '0;
                second_r          <= '0;
                entering_second_r <= 1'b0;
                state_r           <= S_CALC;
              end
              default: ;
            endcase
          end
        end
        S_DIGIT: begin
          if (alu_stat.done) begin
            if (sel_second_r) begin
              second_r <= alu_res;
            end else begin
              first_r <= alu_res;
            end
            state_r <= S_IDLE;
          end
        end
        S_CALC, S_HOLD: begin
          if (alu_stat.done || state_r == S_HOLD) begin
            if (out_free) begin
              out_value_r <= signed'(alu_res);
              out_dz_r    <= alu_stat.dz;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_HOLD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/kic_checker.sv]
// Port-level assertions for the keypad integer calculator, and the bind
// that attaches them to the top level. Depends on kic_pkg.
module kic_checker import kic_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [2:0]            in_command,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_value,
  input logic                  out_dz
);

  // A pending result word is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_dz))
    else $error("result word dropped or changed under stall");

  // Divide by zero always reports a zero value
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_value == '0)
    else $error("divide by zero with nonzero value");

  // A digit keeps the serial unit busy, so the next key waits
  a_digit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_DIGIT |=> !in_ready)
    else $error("key taken while digit still being accumulated");

  // An enter also occupies the block: the key after it waits and the result is not yet out
  a_enter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_ENTER |=> !in_ready && !$rose(out_valid))
    else $error("enter finished too early");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keypad_integer_calculator_top kic_checker #(.DATA_WIDTH(DATA_WIDTH)) u_kic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_dz     (out_ch.divide_by_zero)
);

[dv/tb_keypad_integer_calculator_top.sv]
// Self-checking testbench for keypad_integer_calculator_top: a table of keys,
// then random key sequences, every result word checked against a predictor.
// Depends on kic_pkg, kic_in_if, kic_out_if and the calculator RTL.
`timescale 1ns / 1ps

module tb_keypad_integer_calculator_top import kic_pkg::*;;

  localparam int W = 32;
  localparam int KEY_TARGET = 1450;
  localparam int LONG_HOLD = 600;
  localparam int DRAIN_CYCLES = 2 * W + 8;

  // Codes the block must ignore
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MINUS_ONE = {W{1'b1}};

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                dz;
  } calc_result_t;

  // One directed key; typed marks a row whose answer is written out here
  typedef struct packed {
    logic [2:0]   cmd;
    logic [3:0]   dig;
    logic         typed;
    calc_result_t ans;
  } key_row_t;

  localparam int DIR_ROWS = 33;
  localparam key_row_t DIR_KEYS [DIR_ROWS] = '{
    // enter straight after reset: 0 + 0
    '{CMD_ENTER,  4'd0,  1'b1, '{32'sd0, 1'b0}},
    // first operand 2147483648, built partly with digit 14
    '{CMD_DIGIT,  4'd2,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd1,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd4,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd7,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd4,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd8,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd3,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd5,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd14, 1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd8,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIVIDE, 4'd0,  1'b0, '{32'sd0, 1'b0}},
    // second operand 4294967295 (minus one), ends with digit 15
    '{CMD_DIGIT,  4'd4,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd2,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd9,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd4,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd9,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd6,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd7,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd2,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd8,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd15, 1'b0, '{32'sd0, 1'b0}},
    // most negative over minus one wraps to itself
    '{CMD_ENTER,  4'd0,  1'b1, '{MOST_NEG, 1'b0}},
    '{CMD_UNUSED7, 4'd15, 1'b0, '{32'sd0, 1'b0}},
    // divide stays latched after enter; 0 / 0 flags divide by zero
    '{CMD_ENTER,  4'd0,  1'b1, '{32'sd0, 1'b1}},
    '{CMD_DIGIT,  4'd9,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_PLUS,   4'd0,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd0,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_DIGIT,  4'd7,  1'b0, '{32'sd0, 1'b0}},
    // operator changes while on the second operand keep the 7
    '{CMD_TIMES,  4'd0,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_UNUSED6, 4'd0, 1'b0, '{32'sd0, 1'b0}},
    '{CMD_MINUS,  4'd0,  1'b0, '{32'sd0, 1'b0}},
    '{CMD_ENTER,  4'd0,  1'b0, '{32'sd0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  kic_in_if                     in_ch ();
  kic_out_if #(.DATA_WIDTH(W))  out_ch ();

  keypad_integer_calculator_top #(.DATA_WIDTH(W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state
  logic [W-1:0] opnd_a;
  logic [W-1:0] opnd_b;
  op_t          cur_op;
  bit           on_second;

  calc_result_t answer_q [$];
  int answers_due;
  int keys_sent;
  int keys_ignored;
  int results_seen;
  int dz_seen;
  int errors;
  int holds_done;
  bit hold_req;
  bit calm_run;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the calculator state by one key; returns 1 when enter gives a word
  function automatic bit calc_key(input logic [2:0] cmd, input logic [3:0] dig,
                                  output calc_result_t ans);
    logic signed [W-1:0] sa;
    logic signed [W-1:0] sb;
    ans = '0;
    sa = opnd_a;
    sb = opnd_b;
    case (cmd)
      CMD_DIGIT: begin
        if (on_second) opnd_b = opnd_b * W'(10) + W'(dig);
        else opnd_a = opnd_a * W'(10) + W'(dig);
        return 1'b0;
      end
      CMD_PLUS, CMD_MINUS, CMD_TIMES, CMD_DIVIDE: begin
        cur_op = op_t'(2'(cmd - CMD_PLUS));
        on_second = 1'b1;
        return 1'b0;
      end
      CMD_ENTER: begin
        case (cur_op)
          OP_ADD: ans.value = sa + sb;
          OP_SUB: ans.value = sa - sb;
          OP_MUL: ans.value = sa * sb;
          default: begin
            if (sb == 0) begin
              ans.dz = 1'b1;
            end else if (sa == MOST_NEG && sb == MINUS_ONE) begin
              ans.value = MOST_NEG;
            end else begin
              ans.value = sa / sb;
            end
          end
        endcase
        opnd_a = '0;
        opnd_b = '0;
        on_second = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [3:0] rand_digit();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  // Operand length: short ones keep divide and multiply interesting
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 7);
    return $urandom_range(8, 12);
  endfunction

  // Offer one key word, wait for acceptance, then update the predictor
  task automatic send_key(input logic [2:0] cmd, input logic [3:0] dig,
                          input bit typed = 1'b0, input calc_result_t typed_ans = '0);
    int gap;
    bit has_ans;
    calc_result_t ans;
    gap = calm_run ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.digit   <= dig;
    do @(posedge clk); while (!in_ch.ready);
    has_ans = calc_key(cmd, dig, ans);
    if (has_ans) begin
      answer_q.push_back(typed ? typed_ans : ans);
      answers_due++;
    end
    if (cmd == CMD_UNUSED6 || cmd == CMD_UNUSED7) keys_ignored++;
    else keys_sent++;
  endtask

  // One random calculation: mostly well formed, some noise and broken ones
  task automatic send_calc_seq();
    int r;
    int r2;
    int n_b;
    logic [2:0] op_key;
    calm_run = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: any code, any digit field
      repeat ($urandom_range(1, 4))
        send_key(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
    end else begin
      if (r >= 12) repeat (rand_len()) send_key(CMD_DIGIT, rand_digit());
      if (r >= 16) begin
        op_key = CMD_PLUS + 3'($urandom_range(0, 3));
        send_key(op_key, 4'($urandom_range(0, 15)));
        r2 = $urandom_range(0, 99);
        if (r2 < 12) begin
          n_b = 0;
        end else if (r2 < 22) begin
          // zero divisor built from zero digits
          repeat ($urandom_range(1, 3)) send_key(CMD_DIGIT, 4'd0);
          n_b = 0;
        end else begin
          n_b = rand_len();
        end
        repeat (n_b) send_key(CMD_DIGIT, rand_digit());
        if ($urandom_range(0, 9) == 0)
          send_key(CMD_PLUS + 3'($urandom_range(0, 3)), 4'd0);
        if ($urandom_range(0, 19) == 0)
          send_key($urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7, rand_digit());
      end
      // occasionally no enter: operands run on into the next sequence
      if ($urandom_range(0, 14) != 0) send_key(CMD_ENTER, 4'($urandom_range(0, 15)));
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    calc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.divide_by_zero === 1'b1) dz_seen++;
      if (answers_due == 0) begin
        errors++;
        $display("%0t: unexpected result word value %0d dz %0b", $time,
                 out_ch.value, out_ch.divide_by_zero);
      end else begin
        want = answer_q.pop_front();
        answers_due--;
        if (out_ch.value !== want.value) begin
          errors++;
          $display("%0t: value mismatch: expected %0d, got %0d", $time,
                   want.value, out_ch.value);
        end
        if (out_ch.divide_by_zero !== want.dz) begin
          errors++;
          $display("%0t: divide_by_zero mismatch: expected %0b, got %0b", $time,
                   want.dz, out_ch.divide_by_zero);
        end
      end
    end
  end

  // Result receiver: random stalls, calm chunks, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int chunk_left;
    bit chunk_calm;
    stall_left = 0;
    chunk_left = 0;
    chunk_calm = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (chunk_left == 0) begin
        chunk_left = 200;
        chunk_calm = ($urandom_range(0, 3) == 0);
      end
      chunk_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!chunk_calm && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin : key_source
    bit hold_started;
    bit pause_done;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_DIGIT;
    in_ch.digit = 4'd0;
    opnd_a = '0;
    opnd_b = '0;
    cur_op = OP_ADD;
    on_second = 1'b0;
    answers_due = 0;
    keys_sent = 0;
    keys_ignored = 0;
    results_seen = 0;
    dz_seen = 0;
    errors = 0;
    holds_done = 0;
    hold_req = 1'b0;
    calm_run = 1'b0;
    hold_started = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_key(DIR_KEYS[i].cmd, DIR_KEYS[i].dig, DIR_KEYS[i].typed, DIR_KEYS[i].ans);

    // random sequences
    while (keys_sent < KEY_TARGET) begin
      send_calc_seq();
      if (!hold_started && keys_sent >= 400) begin
        // receiver backs off while keys keep coming
        hold_started = 1'b1;
        hold_req = 1'b1;
      end
      if (!pause_done && keys_sent >= 900) begin
        // sender goes quiet until every result is out
        pause_done = 1'b1;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (answers_due == 0);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (answers_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d keys plus %0d ignored codes; %0d results checked, %0d divide by zero.",
             keys_sent, keys_ignored, results_seen, dz_seen);
    $display("Receiver long hold-offs: %0d, mismatches: %0d.", holds_done, errors);
    if (errors == 0 && answers_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #6_000_000;
    $display("Timeout with %0d results still due.", answers_due);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
